[src/assert_macros.svh]
// assert_macros.svh: assertion macros used by msi_checker.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, switched off while reset is high
`define AST_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Property checked on the rising clock edge, also during reset
`define AST_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

[src/msi_pkg.sv]
// msi_pkg: types and constants of the merge sort with index unit.
// Depends on nothing; used by the top level, msi_seq and msi_checker.
package msi_pkg;

   // default sizes
   localparam int MAX_ITEMS_DEF = 64;
   localparam int KEY_BITS_DEF  = 64;

   // fixed field widths
   localparam int KEY_W = 64;
   localparam int POS_W = 6;

   // input word
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             last_key;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [KEY_W-1:0] sorted_key;
      logic [POS_W-1:0] original_position;
      logic             last_result;
   } rsp_word_type;

   // bank controls from the sequencer
   typedef struct packed {
      logic wr_en0;
      logic wr_en1;
      logic rd_sel;
   } bank_ctrl_type;

endpackage

[src/merge_sort_with_index_unit.sv]
// Merge sort with index: top level, two RAM banks around the sequencer.
// Depends on msi_pkg, msi_ram and msi_seq.
//
// Use: send keys as req_ words, one per accepted word (req_valid high,
// req_stall low). Each key is tagged with its arrival position. The word
// with last_key set closes the set; the unit then sorts the stored keys
// ascending, stable on equal keys, and returns one rsp_ word per key with
// the key, its arrival position and last_result on the final word. Keys
// beyond MAX_ITEMS are dropped; their last_key mark still starts the sort.
// Loading writes each stored key into bank 0. Sorting n keys takes
// ceil(log2 n) passes; each run pair opens with the ST_RUN and ST_HEAD
// head reads, then merges one element per cycle, set by the single read
// port of the source bank. Output words go through ST_OREAD and ST_OCAP.
// req_stall is high from the last key until the final result is loaded
// into the output register; the next set may load while it waits.
// A stalled rsp_ word holds and the sequencer waits on it.
// Reset empties the set and the output register; the banks are not cleared.
module merge_sort_with_index_unit #(
   parameter int MAX_ITEMS = msi_pkg::MAX_ITEMS_DEF,
   parameter int KEY_BITS  = msi_pkg::KEY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  msi_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output msi_pkg::rsp_word_type rsp_word
);
   import msi_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int ENT_W = KEY_BITS + POS_W;

   bank_ctrl_type      bank_ctrl;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENT_W-1:0]   wr_data;
   logic [ENT_W-1:0]   bank0_q;
   logic [ENT_W-1:0]   bank1_q;
   logic [ENT_W-1:0]   rd_data;

   // sequencer
   msi_seq #(
      .MAX_ITEMS (MAX_ITEMS),
      .KEY_BITS  (KEY_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .bank_ctrl (bank_ctrl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   // ping-pong banks of {key, position}
   msi_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ITEMS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (bank_ctrl.wr_en0),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (bank0_q)
   );

   msi_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ITEMS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (bank_ctrl.wr_en1),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (bank1_q)
   );

   // source bank select
   assign rd_data = bank_ctrl.rd_sel ? bank1_q : bank0_q;

endmodule

[src/msi_ram.sv]
// msi_ram: generic single-port-write, single-port-read RAM, registered read.
// Depends on nothing.
module msi_ram #(
   parameter int WIDTH = 70,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/msi_seq.sv]
// msi_seq: load, merge-pass and output sequencer of the merge sort unit.
// Depends on msi_pkg; drives two msi_ram banks through the top level.
module msi_seq #(
   parameter int MAX_ITEMS = msi_pkg::MAX_ITEMS_DEF,
   parameter int KEY_BITS  = msi_pkg::KEY_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  msi_pkg::req_word_type                  req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output msi_pkg::rsp_word_type                  rsp_word,
   output msi_pkg::bank_ctrl_type                 bank_ctrl,
   output logic [$clog2(MAX_ITEMS)-1:0]           rd_addr,
   output logic [$clog2(MAX_ITEMS)-1:0]           wr_addr,
   output logic [KEY_BITS+msi_pkg::POS_W-1:0]     wr_data,
   input  logic [KEY_BITS+msi_pkg::POS_W-1:0]     rd_data
);
   import msi_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int RUN_W = CNT_W + 2;
   localparam int ENT_W = KEY_BITS + POS_W;

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_RUN   = 6'b000010,
      ST_HEAD  = 6'b000100,
      ST_MERGE = 6'b001000,
      ST_OREAD = 6'b010000,
      ST_OCAP  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   out_i_ff, out_i_in;
   logic [RUN_W-1:0]   w_ff, w_in;
   logic [RUN_W-1:0]   s_ff, s_in;
   logic [RUN_W-1:0]   mid_ff, mid_in;
   logic [RUN_W-1:0]   hi_ff, hi_in;
   logic [RUN_W-1:0]   a_ff, a_in;
   logic [RUN_W-1:0]   b_ff, b_in;
   logic [RUN_W-1:0]   k_ff, k_in;
   logic               sel_ff, sel_in;
   logic               fresh_ff, fresh_in;
   logic               fresh_b_ff, fresh_b_in;
   logic [ENT_W-1:0]   head_a_ff, head_a_in;
   logic [ENT_W-1:0]   head_b_ff, head_b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic               accept;
   logic               rsp_fire;
   logic               store_ok;
   logic [CNT_W-1:0]   n_load;
   logic [RUN_W-1:0]   n_ext;
   logic [RUN_W-1:0]   mid_c;
   logic [RUN_W-1:0]   hi_c;
   logic [RUN_W-1:0]   s_next;
   logic [RUN_W-1:0]   w_dbl;
   logic [RUN_W-1:0]   a_next;
   logic [RUN_W-1:0]   b_next;
   logic [RUN_W-1:0]   k_next;
   logic [ENT_W-1:0]   eff_a;
   logic [ENT_W-1:0]   eff_b;
   logic               a_live;
   logic               b_live;
   logic               take_a;
   logic               out_last;

   // handshakes
   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // set size at the last key; a full store drops the key
   assign store_ok = (count_ff < CNT_W'(MAX_ITEMS));
   assign n_load   = store_ok ? CNT_W'(count_ff + 1'b1) : count_ff;
   assign n_ext    = RUN_W'(n_ff);

   // run bounds, clamped to the set size
   assign mid_c  = ((s_ff + w_ff) > n_ext) ? n_ext : RUN_W'(s_ff + w_ff);
   assign hi_c   = ((s_ff + (w_ff << 1)) > n_ext) ? n_ext : RUN_W'(s_ff + (w_ff << 1));
   assign s_next = RUN_W'(s_ff + (w_ff << 1));
   assign w_dbl  = RUN_W'(w_ff << 1);
   assign a_next = RUN_W'(a_ff + 1'b1);
   assign b_next = RUN_W'(b_ff + 1'b1);
   assign k_next = RUN_W'(k_ff + 1'b1);

   // heads with the fresh read forwarded; left run wins ties
   assign eff_a  = (fresh_ff && !fresh_b_ff) ? rd_data : head_a_ff;
   assign eff_b  = (fresh_ff && fresh_b_ff) ? rd_data : head_b_ff;
   assign a_live = (a_ff < mid_ff);
   assign b_live = (b_ff < hi_ff);
   assign take_a = a_live && (!b_live || (eff_a[ENT_W-1:POS_W] <= eff_b[ENT_W-1:POS_W]));

   assign out_last = (CNT_W'(out_i_ff + 1'b1) == n_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      out_i_in     = out_i_ff;
      w_in         = w_ff;
      s_in         = s_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      fresh_in     = fresh_ff;
      fresh_b_in   = fresh_b_ff;
      head_a_in    = head_a_ff;
      head_b_in    = head_b_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;

      bank_ctrl.wr_en0 = 1'b0;
      bank_ctrl.wr_en1 = 1'b0;
      bank_ctrl.rd_sel = sel_ff;
      rd_addr = out_i_ff[IDX_W-1:0];
      wr_addr = k_ff[IDX_W-1:0];
      wr_data = take_a ? eff_a : eff_b;

      case (state_ff)
         ST_LOAD: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_data = {req_word.key[KEY_BITS-1:0], POS_W'(count_ff)};
            if (accept) begin
               if (store_ok) begin
                  bank_ctrl.wr_en0 = 1'b1;
                  count_in = CNT_W'(count_ff + 1'b1);
               end
               if (req_word.last_key) begin
                  n_in     = n_load;
                  count_in = '0;
                  w_in     = RUN_W'(1);
                  s_in     = '0;
                  sel_in   = 1'b0;
                  out_i_in = '0;
                  fresh_in = 1'b0;
                  if (n_load <= CNT_W'(1)) begin
                     state_in = ST_OREAD;
                  end else begin
                     state_in = ST_RUN;
                  end
               end
            end
         end
         // open a run pair: read left head
         ST_RUN: begin
            mid_in   = mid_c;
            hi_in    = hi_c;
            a_in     = s_ff;
            b_in     = mid_c;
            k_in     = s_ff;
            rd_addr  = s_ff[IDX_W-1:0];
            fresh_in = 1'b0;
            state_in = ST_HEAD;
         end
         // left head lands, read right head
         ST_HEAD: begin
            head_a_in  = rd_data;
            rd_addr    = mid_ff[IDX_W-1:0];
            fresh_in   = 1'b1;
            fresh_b_in = 1'b1;
            state_in   = ST_MERGE;
         end
         // one element a cycle into the other bank
         ST_MERGE: begin
            head_a_in = eff_a;
            head_b_in = eff_b;
            if (sel_ff) begin
               bank_ctrl.wr_en0 = 1'b1;
            end else begin
               bank_ctrl.wr_en1 = 1'b1;
            end
            k_in     = k_next;
            fresh_in = 1'b1;
            if (take_a) begin
               a_in       = a_next;
               rd_addr    = a_next[IDX_W-1:0];
               fresh_b_in = 1'b0;
            end else begin
               b_in       = b_next;
               rd_addr    = b_next[IDX_W-1:0];
               fresh_b_in = 1'b1;
            end
            if (k_next == hi_ff) begin
               if (s_next >= n_ext) begin
                  sel_in = !sel_ff;
                  if (w_dbl >= n_ext) begin
                     out_i_in = '0;
                     state_in = ST_OREAD;
                  end else begin
                     s_in     = '0;
                     w_in     = w_dbl;
                     state_in = ST_RUN;
                  end
               end else begin
                  s_in     = s_next;
                  state_in = ST_RUN;
               end
            end
         end
         ST_OREAD: begin
            state_in = ST_OCAP;
         end
         // word into the output register once it is free
         ST_OCAP: begin
            if (!rsp_valid_ff || rsp_fire) begin
               rsp_in.sorted_key        = KEY_W'(rd_data[ENT_W-1:POS_W]);
               rsp_in.original_position = rd_data[POS_W-1:0];
               rsp_in.last_result       = out_last;
               rsp_valid_in             = 1'b1;
               out_i_in                 = CNT_W'(out_i_ff + 1'b1);
               if (out_last) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_OREAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         n_ff         <= '0;
         out_i_ff     <= '0;
         w_ff         <= RUN_W'(1);
         s_ff         <= '0;
         mid_ff       <= '0;
         hi_ff        <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         k_ff         <= '0;
         sel_ff       <= 1'b0;
         fresh_ff     <= 1'b0;
         fresh_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         out_i_ff     <= out_i_in;
         w_ff         <= w_in;
         s_ff         <= s_in;
         mid_ff       <= mid_in;
         hi_ff        <= hi_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         k_ff         <= k_in;
         sel_ff       <= sel_in;
         fresh_ff     <= fresh_in;
         fresh_b_ff   <= fresh_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_a_ff <= head_a_in;
      head_b_ff <= head_b_in;
      rsp_ff    <= rsp_in;
   end

endmodule

[src/msi_checker.sv]
// msi_checker: port-level assertions for merge_sort_with_index_unit, bound in.
// Depends on msi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module msi_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input msi_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input msi_pkg::rsp_word_type rsp_word
);

   // a stalled result word stays offered and unchanged
   `AST_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))

   // after reset nothing is offered and a new set may load
   `AST_ALL(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall)

   // a key without the last mark keeps the unit loading
   `AST_RST(a_load_open, clock, reset,
      req_valid && !req_stall && !req_word.last_key |=> !req_stall)

   // the last key closes the set: input stalls in the next cycle
   `AST_RST(a_last_close, clock, reset,
      req_valid && !req_stall && req_word.last_key |=> req_stall)

endmodule

bind merge_sort_with_index_unit msi_checker u_checker (.*);
